FILE: sv/derivation_path_parser_defines.svh
// Assertion macros for the derivation path parser.
// Used by derivation_path_parser.sv; expects clk and rst in scope.
`ifndef DERIVATION_PATH_PARSER_DEFINES_SVH
`define DERIVATION_PATH_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dpp_pkg.sv
// Shared types and constants for the derivation path parser.
// No dependencies; imported by dpp_cfg, dpp_step and the top level.
`timescale 1ns / 1ps

package dpp_pkg;

  localparam logic [2:0] PH_M      = 3'd0;
  localparam logic [2:0] PH_AFTERM = 3'd1;
  localparam logic [2:0] PH_START  = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_AFTERH = 3'd4;
  localparam logic [2:0] PH_ERR    = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_DEEP = 2'd2;

  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_LOW_H = 8'h68;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [31:0] HARD_BIT = 32'h8000_0000;

  localparam logic [7:0] DEPTH_LIMIT_RST = 8'd8;
  localparam logic       REG_DEPTH_LIMIT = 1'b0;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] value_acc;
    logic [7:0]  comp_count;
    logic [1:0]  err_code;
  } state_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] index;
    logic        index_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [7:0]  count;
  } result_t;

endpackage

FILE: sv/dpp_cfg.sv
// APB-style register block holding depth_limit.
// Depends on dpp_pkg.
`timescale 1ns / 1ps

module dpp_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  depth_limit
);
  import dpp_pkg::*;

  logic wr_en;
  logic sel_depth;

  assign pready    = 1'b1;
  assign sel_depth = (paddr[2] == REG_DEPTH_LIMIT);
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= DEPTH_LIMIT_RST;
    end else if (wr_en && sel_depth) begin
      depth_limit <= pwdata[7:0];
    end
  end

  assign prdata = sel_depth ? {24'd0, depth_limit} : 32'd0;

endmodule

FILE: sv/dpp_step.sv
// Per-character parse step: next state and result for one path byte.
// Depends on dpp_pkg.
`timescale 1ns / 1ps

module dpp_step (
  input  dpp_pkg::state_t  cur,
  input  logic [7:0]       ch,
  input  logic [7:0]       depth_limit,
  output dpp_pkg::state_t  nxt,
  output dpp_pkg::result_t res
);
  import dpp_pkg::*;

  logic        is_digit;
  logic        is_hard;
  logic [3:0]  digit;
  logic [35:0] wide;
  logic        ovf;
  logic [7:0]  cnt_inc;
  logic [1:0]  st;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_hard  = (ch == CH_APOS) || (ch == CH_LOW_H) || (ch == CH_UP_H);
  assign digit    = ch[3:0];
  // acc * 10 + digit as shift-add
  assign wide     = ({4'd0, cur.value_acc} << 3) + ({4'd0, cur.value_acc} << 1)
                  + {32'd0, digit};
  assign ovf      = |wide[35:32];
  assign cnt_inc  = cur.comp_count + 8'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    st  = ST_OK;
    if (ch == CH_NUL) begin
      case (cur.phase)
        PH_M:   st = ST_BAD;
        PH_ERR: st = cur.err_code;
        default: st = ST_OK;
      endcase
      res.emit     = 1'b1;
      res.done_res = 1'b1;
      res.status   = st;
      if (cur.phase == PH_DIGITS) begin
        res.index       = cur.value_acc;
        res.index_valid = 1'b1;
        res.count       = cnt_inc;
      end else if (st == ST_OK) begin
        res.count = cur.comp_count;
      end
      nxt = '0;
      nxt.phase = PH_M;
    end else begin
      case (cur.phase)
        PH_M: begin
          if (ch == CH_M) begin
            nxt.phase = PH_AFTERM;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_BAD;
          end
        end
        PH_AFTERM, PH_AFTERH: begin
          if (ch == CH_SLASH) begin
            nxt.phase = PH_START;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_BAD;
          end
        end
        PH_START: begin
          if (cur.comp_count >= depth_limit) begin
            nxt.phase = PH_ERR; nxt.err_code = ST_DEEP;
          end else if (is_digit) begin
            nxt.value_acc = {28'd0, digit};
            nxt.phase     = PH_DIGITS;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_BAD;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (ovf) begin
              nxt.phase = PH_ERR; nxt.err_code = ST_BAD;
            end else begin
              nxt.value_acc = wide[31:0];
            end
          end else if (is_hard) begin
            if ((cur.value_acc & HARD_BIT) != 32'd0) begin
              nxt.phase = PH_ERR; nxt.err_code = ST_BAD;
            end else begin
              res.emit        = 1'b1;
              res.index       = cur.value_acc | HARD_BIT;
              res.index_valid = 1'b1;
              nxt.comp_count  = cnt_inc;
              nxt.phase       = PH_AFTERH;
            end
          end else if (ch == CH_SLASH) begin
            res.emit        = 1'b1;
            res.index       = cur.value_acc;
            res.index_valid = 1'b1;
            nxt.comp_count  = cnt_inc;
            nxt.phase       = PH_START;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_BAD;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/derivation_path_parser.sv
// Derivation path parser top level: input register, parse step, result register.
// Depends on dpp_pkg, dpp_cfg, dpp_step and derivation_path_parser_defines.svh.
//
// Usage: path characters enter on the s_* stream, one byte per beat, in
// s_tdata[7:0]. A zero byte ends a path. Each finished component leaves on
// the m_* stream with m_tuser (index_valid) set; the terminator always
// gives one beat with m_tlast (done_res) set carrying status and count.
// Bytes that finish nothing give no output beat.
// Pipeline: a taken byte passes the input register, then the parse step into the result register.
// Throughput: one byte per cycle while the output is not held; the parse state,
// updated by one shift-add and compare step, is the only loop.
// Stall: a held output beat stays put; the input register still takes a
// byte while it is empty, then backs up.
// Reset clears both stages and the parse state; depth_limit returns to 8. The user
// writes depth_limit (APB address 0) only while the stream is idle; nothing checks it.
`timescale 1ns / 1ps
`include "derivation_path_parser_defines.svh"

module derivation_path_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] index, [33:32] status, [41:34] count, zero pad
  output logic        m_tuser,   // index_valid
  output logic        m_tlast,   // done_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dpp_pkg::*;

  logic       in_valid;
  logic [7:0] ch_q;
  logic       advance;
  logic [7:0] depth_limit;
  state_t     state;
  state_t     state_next;
  result_t    res;
  logic [31:0] out_index;
  logic [1:0]  out_status;
  logic [7:0]  out_count;

  dpp_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .depth_limit(depth_limit)
  );

  dpp_step u_step (
    .cur        (state),
    .ch         (ch_q),
    .depth_limit(depth_limit),
    .nxt        (state_next),
    .res        (res)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance || !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      ch_q <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && res.emit;
      if (in_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_index  <= res.index;
      out_status <= res.status;
      out_count  <= res.count;
      m_tuser    <= res.index_valid;
      m_tlast    <= res.done_res;
    end
  end

  assign m_tdata = {6'd0, out_count, out_status, out_index};

  `DPP_ASSERT_NEXT(a_term_clears, advance && in_valid && (ch_q == CH_NUL), state.phase == PH_M, "terminator did not clear the parse state")
  `DPP_ASSERT_NOW(a_mid_has_index, m_tvalid && !m_tlast, m_tuser && (out_status == ST_OK), "non-final beat without an index")
  `DPP_ASSERT_NOW(a_bad_no_count, m_tvalid && (out_status != ST_OK), out_count == 8'd0 && m_tlast, "error status with nonzero count")
  `DPP_ASSERT_NOW(a_no_index_zero, m_tvalid && !m_tuser, out_index == 32'd0, "index set without index_valid")

endmodule

FILE: tb/path_parse_checker.sv
// Checker for the derivation path parser: predicts the result beat of every
// accepted path byte and compares it with the output stream. Depends on dpp_pkg.
`timescale 1ns / 1ps

module path_parse_checker
  import dpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding
);

  localparam logic [2:0] ADDR_DEPTH_LIMIT = {REG_DEPTH_LIMIT, 2'b00};

  logic [7:0]  depth_lim;
  logic [2:0]  ph;
  logic [31:0] acc;
  logic [7:0]  ncomp;
  logic [1:0]  err_st;
  result_t     exp_beats[$];

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_hard(input logic [7:0] c);
    return c == CH_APOS || c == CH_LOW_H || c == CH_UP_H;
  endfunction

  task automatic clear_path();
    ph = PH_M;
    acc = '0;
    ncomp = '0;
    err_st = ST_OK;
  endtask

  task automatic abort_path(input logic [1:0] code);
    err_st = code;
    ph = PH_ERR;
  endtask

  task automatic parse_char(input logic [7:0] c, output result_t r);
    logic [63:0] nv;
    logic [1:0]  st;
    r = '0;
    if (c == CH_NUL) begin
      if (ph == PH_M) begin
        st = ST_BAD;
      end else if (ph == PH_ERR) begin
        st = err_st;
      end else begin
        st = ST_OK;
        if (ph == PH_DIGITS) begin
          r.index_valid = 1'b1;
          r.index = acc;
          ncomp = ncomp + 8'd1;
        end
      end
      r.emit = 1'b1;
      r.done_res = 1'b1;
      r.status = st;
      r.count = (st == ST_OK) ? ncomp : 8'd0;
      clear_path();
    end else begin
      case (ph)
        PH_M: begin
          if (c == CH_M) ph = PH_AFTERM;
          else abort_path(ST_BAD);
        end
        PH_AFTERM, PH_AFTERH: begin
          if (c == CH_SLASH) ph = PH_START;
          else abort_path(ST_BAD);
        end
        PH_START: begin
          if (ncomp >= depth_lim) begin
            abort_path(ST_DEEP);
          end else if (is_dec(c)) begin
            acc = {24'd0, c - CH_ZERO};
            ph = PH_DIGITS;
          end else begin
            abort_path(ST_BAD);
          end
        end
        PH_DIGITS: begin
          if (is_dec(c)) begin
            nv = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
            if (nv > 64'hFFFF_FFFF) abort_path(ST_BAD);
            else acc = nv[31:0];
          end else if (is_hard(c)) begin
            if ((acc & HARD_BIT) != '0) begin
              abort_path(ST_BAD);
            end else begin
              r.index_valid = 1'b1;
              r.index = acc | HARD_BIT;
              ncomp = ncomp + 8'd1;
              ph = PH_AFTERH;
            end
          end else if (c == CH_SLASH) begin
            r.index_valid = 1'b1;
            r.index = acc;
            ncomp = ncomp + 8'd1;
            ph = PH_START;
          end else begin
            abort_path(ST_BAD);
          end
        end
        default: ;
      endcase
      r.emit = r.index_valid;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t r;
    result_t w;
    if (rst) begin
      depth_lim = DEPTH_LIMIT_RST;
      clear_path();
      exp_beats.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (exp_beats.size() == 0) begin
          $error("result beat with nothing expected: tdata 0x%0h", m_tdata);
          errors++;
        end else begin
          w = exp_beats.pop_front();
          check_field("index", w.index, m_tdata[31:0]);
          check_field("index_valid", {31'd0, w.index_valid}, {31'd0, m_tuser});
          check_field("done_res", {31'd0, w.done_res}, {31'd0, m_tlast});
          check_field("status", {30'd0, w.status}, {30'd0, m_tdata[33:32]});
          check_field("count", {24'd0, w.count}, {24'd0, m_tdata[41:34]});
          check_field("tdata pad", 32'd0, {26'd0, m_tdata[47:42]});
        end
      end
      if (s_tvalid && s_tready) begin
        parse_char(s_tdata, r);
        if (r.emit) exp_beats.push_back(r);
      end
      if (psel && penable && pready && paddr == ADDR_DEPTH_LIMIT) begin
        if (pwrite) depth_lim = pwdata[7:0];
        else check_field("depth_limit readback", {24'd0, depth_lim}, prdata);
      end
    end
    outstanding = exp_beats.size();
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for derivation_path_parser: clock, reset, path byte stimulus,
// APB register writes and reads and the verdict. Depends on dpp_pkg and path_parse_checker.
`timescale 1ns / 1ps

module tb_top;
  import dpp_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam logic [2:0] ADDR_DEPTH_LIMIT = {REG_DEPTH_LIMIT, 2'b00};
  localparam logic [2:0] ADDR_SPARE = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;  // [31:0] index, [33:32] status, [41:34] count, zero pad
  logic        m_tuser;  // index_valid
  logic        m_tlast;  // done_res
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          errors;
  int          outstanding;
  int          cycle_cnt = 0;
  int          hold_req = 0;
  bit          quiet_tx = 1'b0;
  bit          quiet_rx = 1'b0;
  logic [7:0]  cur_depth = DEPTH_LIMIT_RST;
  logic [7:0]  path_q[$];

  always #5 clk = ~clk;

  derivation_path_parser u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  path_parse_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output side: random stalls, plus long hold-offs on request
  initial begin
    int stall;
    int served;
    stall = 0;
    served = 0;
    forever begin
      @(negedge clk);
      if (served != hold_req) begin
        served = hold_req;
        m_tready = 1'b0;
        repeat (300) @(negedge clk);
      end
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if (!quiet_rx) stall = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_path();
    foreach (path_q[i]) send_byte(path_q[i]);
    send_byte(CH_NUL);
    path_q.delete();
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
    send_path();
  endtask

  task automatic put_dec(input logic [63:0] v);
    logic [7:0]  digs[$];
    logic [63:0] x;
    x = v;
    do begin
      digs.push_front(CH_ZERO + 8'(x % 10));
      x = x / 10;
    end while (x != 0);
    foreach (digs[i]) path_q.push_back(digs[i]);
  endtask

  task automatic put_component();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 999);
      4, 5:       v = $urandom;
      6:          v = 64'hFFFF_FFFF - $urandom_range(0, 3);
      7:          v = 64'hFFFF_FFFF + $urandom_range(1, 20);
      8:          v = {32'd0, HARD_BIT} + $urandom_range(0, 1000);
      default:    v = 64'd99_999_999_999;
    endcase
    if ($urandom_range(0, 7) == 0) path_q.push_back(CH_ZERO);
    put_dec(v);
    case ($urandom_range(0, 5))
      0: path_q.push_back(CH_APOS);
      1: path_q.push_back(CH_LOW_H);
      2: path_q.push_back(CH_UP_H);
      default: ;
    endcase
  endtask

  task automatic random_path();
    int kind;
    int n;
    int lim;
    kind = $urandom_range(0, 99);
    quiet_tx = ($urandom_range(0, 9) == 0);
    quiet_rx = ($urandom_range(0, 9) == 0);
    if (kind < 20) begin
      if ($urandom_range(0, 1)) path_q.push_back(CH_M);
      n = $urandom_range(0, 8);
      repeat (n) path_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      path_q.push_back(CH_M);
      lim = (cur_depth < 5) ? cur_depth + 1 : 6;
      n = $urandom_range(0, lim);
      if (n > 0 || $urandom_range(0, 3) == 0) path_q.push_back(CH_SLASH);
      for (int i = 0; i < n; i++) begin
        if (i > 0) path_q.push_back(CH_SLASH);
        put_component();
      end
      if (n > 0 && $urandom_range(0, 4) == 0) path_q.push_back(CH_SLASH);
      if (kind < 32) path_q[$urandom_range(0, path_q.size() - 1)] = 8'($urandom_range(1, 255));
    end
    send_path();
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] depth, input int npaths);
    settle();
    apb_access(1'b1, ADDR_DEPTH_LIMIT, {24'($urandom), depth});
    apb_access(1'b0, ADDR_DEPTH_LIMIT, '0);
    cur_depth = depth;
    repeat (npaths) random_path();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty path, bare m, trailing slash, largest index, hardened overflow, bad start
    send_str("");
    send_str("m");
    send_str("m/0'/");
    send_str("m/4294967295");
    send_str("m/2147483648H");
    send_str("x");

    settle();
    apb_access(1'b1, ADDR_SPARE, $urandom);
    apb_access(1'b0, ADDR_DEPTH_LIMIT, '0);
    repeat (6) random_path();

    run_phase(8'd0, 8);
    run_phase(8'd1, 10);

    // full depth with the output held off: the block backs up into its input
    run_phase(8'd255, 5);
    path_q.push_back(CH_M);
    for (int i = 0; i < 255; i++) begin
      path_q.push_back(CH_SLASH);
      path_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end
    quiet_tx = 1'b1;
    hold_req++;
    send_path();
    repeat (3) random_path();

    run_phase(8'd2, 10);
    run_phase(8'($urandom_range(3, 254)), 6);
    run_phase(8'd3, 8);

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
